>>> src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

// property checked outside reset
`define ASSERT_DIS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`endif

>>> src/arpc_pkg.sv
// types, codes and constants of the arp cache responder
package arpc_pkg;

  localparam int DEFAULT_CACHE_ENTRIES = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [10:0] MIN_PKT_LEN = 11'd28;
  localparam logic [15:0] HTYPE_ETH = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] HW_ADDR_LEN = 8'd6;
  localparam logic [7:0] PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY = 16'd2;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] LIFETIME_RESET = 32'd60000;

  localparam logic [1:0] FUNC_PACKET = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] REG_LOCAL_IP = 2'd0;
  localparam logic [1:0] REG_LIFETIME = 2'd2;

  localparam logic [2:0] ST_DROPPED = 3'd0;
  localparam logic [2:0] ST_LEARNED = 3'd1;
  localparam logic [2:0] ST_REPLIED = 3'd2;
  localparam logic [2:0] ST_HIT = 3'd3;
  localparam logic [2:0] ST_MISS = 3'd4;
  localparam logic [2:0] ST_TICK = 3'd5;

  localparam logic [1:0] OUT_OP_NONE = 2'd0;
  localparam logic [1:0] OUT_OP_REQUEST = 2'd1;
  localparam logic [1:0] OUT_OP_REPLY = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [10:0] packet_len;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0] hw_len;
    logic [7:0] proto_len;
    logic [15:0] opcode;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [31:0] dest_ip;
    logic [31:0] query_ip;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic send_frame;
    logic [1:0] out_opcode;
    logic [47:0] peer_mac;
    logic [31:0] peer_ip;
    logic [47:0] found_mac;
  } result_t;

  typedef enum logic [2:0] {
    CMD_DROP,
    CMD_LEARN,
    CMD_LEARN_REPLY,
    CMD_LOOKUP,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [31:0] ip;
    logic [47:0] mac;
  } cmd_t;

endpackage

>>> src/arp_cache_responder.sv
// ARP responder with an expiring IPv4-to-MAC cache. A word is taken when start
// is high and busy is low; when the block was empty, the word passes the queue
// and the S_EVAL registers of the back end before its result is registered on
// result, where it stays; done is high with it for one cycle. The back end
// handles each word in S_EVAL, comparing every cache entry at once, then in
// S_COMMIT, writing back; it takes no new word before the last is written
// back. A two-word command queue in front of it lets busy stay low while
// the back end works, and busy rises only when that queue is full. done
// cannot be held off: the receiver must take each result in its cycle.
// Register 1 (local mac) is taken but not stored: the sender address of the
// sent frame is filled in where the frame is built.
module arp_cache_responder
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  item_t       item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        done,
  output result_t     result
);

  logic [31:0] local_ip;
  logic [31:0] lifetime;
  cmd_t front_cmd;
  cmd_t head;
  logic empty;
  logic full;
  logic pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip <= '0;
      lifetime <= LIFETIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_IP: local_ip <= cfg_data[31:0];
        REG_LIFETIME: lifetime <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign busy = full;

  arpc_front u_front (
    .item(item),
    .local_ip(local_ip),
    .cmd(front_cmd)
  );

  arpc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(start),
    .push_cmd(front_cmd),
    .pop(pop),
    .head(head),
    .empty(empty),
    .full(full)
  );

  arpc_back #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .head_valid(!empty),
    .lifetime(lifetime),
    .pop(pop),
    .done(done),
    .result(result)
  );

endmodule

>>> src/arpc_front.sv
// front end: checks a word and turns it into a cache command
module arpc_front
  import arpc_pkg::*;
(
  input  item_t       item,
  input  logic [31:0] local_ip,
  output cmd_t        cmd
);

  logic pkt_ok;

  assign pkt_ok = (item.packet_len >= MIN_PKT_LEN) && (item.hw_type == HTYPE_ETH) &&
                  (item.proto_type == PTYPE_IPV4) && (item.hw_len == HW_ADDR_LEN) &&
                  (item.proto_len == PROTO_ADDR_LEN) && (item.dest_ip == local_ip);

  always_comb begin
    cmd.kind = CMD_DROP;
    cmd.ip = item.sender_ip;
    cmd.mac = item.sender_mac;
    unique case (item.func)
      FUNC_PACKET: begin
        if (pkt_ok && item.opcode == ARP_OP_REPLY) begin
          cmd.kind = CMD_LEARN;
        end else if (pkt_ok && item.opcode == ARP_OP_REQUEST) begin
          cmd.kind = CMD_LEARN_REPLY;
        end
      end
      FUNC_LOOKUP: begin
        cmd.kind = CMD_LOOKUP;
        cmd.ip = item.query_ip;
      end
      FUNC_TICK: begin
        cmd.kind = CMD_TICK;
      end
      default: begin
        cmd.kind = CMD_DROP;
      end
    endcase
  end

endmodule

>>> src/arpc_queue.sv
// short command queue between front and back end
module arpc_queue
  import arpc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign empty = (count == '0);
  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/arpc_back.sv
// back end: cache entries, clock, lookup and write-back
module arpc_back
  import arpc_pkg::*;
#(
  parameter int CACHE_ENTRIES = DEFAULT_CACHE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        head_valid,
  input  logic [31:0] lifetime,
  output logic        pop,
  output logic        done,
  output result_t     result
);

  localparam int IDX_W = $clog2(CACHE_ENTRIES);

  typedef enum logic {S_EVAL, S_COMMIT} state_t;

  state_t state;
  logic [CACHE_ENTRIES-1:0] valid;
  logic [31:0] entry_addr [CACHE_ENTRIES];
  logic [47:0] entry_hw [CACHE_ENTRIES];
  logic [63:0] entry_deadline [CACHE_ENTRIES];
  logic [63:0] now_ms;

  cmd_t cmd;
  logic hit;
  logic [47:0] hit_mac;
  logic [IDX_W-1:0] slot;
  logic [63:0] deadline;

  logic hit_next;
  logic [47:0] hit_mac_next;
  logic [IDX_W-1:0] slot_next;
  logic same_any;
  logic free_any;
  logic [IDX_W-1:0] same_idx;
  logic [IDX_W-1:0] free_idx;
  logic [CACHE_ENTRIES-1:0] same_ip;
  logic [CACHE_ENTRIES-1:0] live;
  logic [CACHE_ENTRIES-1:0] is_free;
  result_t result_next;
  logic learn;

  assign pop = (state == S_EVAL) && head_valid;
  assign learn = (cmd.kind == CMD_LEARN) || (cmd.kind == CMD_LEARN_REPLY);

  // parallel compare of all entries against the head command
  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      same_ip[i] = (valid[i] ? entry_addr[i] : 32'd0) == head.ip;
      live[i] = (valid[i] ? entry_deadline[i] : 64'd0) > now_ms;
      is_free[i] = !valid[i] || entry_addr[i] == 32'd0 || !live[i];
    end
  end

  always_comb begin
    hit_next = 1'b0;
    hit_mac_next = '0;
    same_any = 1'b0;
    free_any = 1'b0;
    same_idx = '0;
    free_idx = '0;
    for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (same_ip[i] && live[i]) begin
        hit_next = 1'b1;
        hit_mac_next = entry_hw[i];
      end
      if (same_ip[i]) begin
        same_any = 1'b1;
        same_idx = IDX_W'(i);
      end
      if (is_free[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    slot_next = same_any ? same_idx : (free_any ? free_idx : '0);
  end

  always_comb begin
    result_next = '0;
    case (cmd.kind)
      CMD_LEARN: begin
        result_next.status = ST_LEARNED;
      end
      CMD_LEARN_REPLY: begin
        result_next.status = ST_REPLIED;
        result_next.send_frame = 1'b1;
        result_next.out_opcode = OUT_OP_REPLY;
        result_next.peer_mac = cmd.mac;
        result_next.peer_ip = cmd.ip;
      end
      CMD_LOOKUP: begin
        if (hit) begin
          result_next.status = ST_HIT;
          result_next.found_mac = hit_mac;
        end else begin
          result_next.status = ST_MISS;
          result_next.send_frame = 1'b1;
          result_next.out_opcode = OUT_OP_REQUEST;
          result_next.peer_mac = BCAST_MAC;
          result_next.peer_ip = cmd.ip;
        end
      end
      CMD_TICK: begin
        result_next.status = ST_TICK;
      end
      default: begin
        result_next.status = ST_DROPPED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL) begin
      cmd <= head;
      hit <= hit_next;
      hit_mac <= hit_mac_next;
      slot <= slot_next;
      deadline <= now_ms + {32'd0, lifetime};
    end
    if (state == S_COMMIT) begin
      result <= result_next;
      if (learn) begin
        entry_addr[slot] <= cmd.ip;
        entry_hw[slot] <= cmd.mac;
        entry_deadline[slot] <= deadline;
      end
    end
    if (rst) begin
      state <= S_EVAL;
      done <= 1'b0;
      valid <= '0;
      now_ms <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_EVAL: begin
          if (head_valid) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          done <= 1'b1;
          if (learn) begin
            valid[slot] <= 1'b1;
          end
          if (cmd.kind == CMD_TICK) begin
            now_ms <= now_ms + 64'd1;
          end
          state <= S_EVAL;
        end
        default: begin
          state <= S_EVAL;
        end
      endcase
    end
  end

endmodule

>>> src/arpc_checker.sv
// port-level checks of the arp cache responder and their bind
`include "assert_macros.svh"

module arpc_checker
  import arpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input result_t     result
);

  `ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> (!done && !busy))
  `ASSERT_DIS(a_done_spaced, clk, rst, done |=> !done)
  `ASSERT_DIS(a_send_matches_status, clk, rst,
    done |-> (result.send_frame ==
              (result.status == ST_REPLIED || result.status == ST_MISS)))
  `ASSERT_DIS(a_hit_sends_nothing, clk, rst,
    (done && result.status == ST_HIT) |->
      (result.out_opcode == OUT_OP_NONE && result.peer_mac == 48'd0))

endmodule

bind arp_cache_responder arpc_checker u_arpc_checker (.*);

>>> sim/tb_arp_cache_responder.sv
// testbench for arp_cache_responder: directed table, then random traffic against a predictor
`timescale 1ns / 1ps

module tb_arp_cache_responder;
  import arpc_pkg::*;

  localparam int SLOTS = DEFAULT_CACHE_ENTRIES;
  localparam int POOL = 20;
  localparam int PHASES = 7;
  localparam int WORDS_PER_PHASE = 250;
  localparam logic [1:0] REG_LOCAL_MAC = 2'd1;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef struct {
    item_t   w;
    bit      typed;
    result_t want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic        done;
  result_t     result;

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [31:0] lifetime_ms;
  logic [31:0] cache_ip [SLOTS];
  logic [47:0] cache_mac [SLOTS];
  logic [63:0] cache_deadline [SLOTS];
  logic [63:0] clock_ms;

  logic [31:0] peer_pool [POOL];
  result_t     answers_due [$];
  row_t        plan [$];
  int          mismatches = 0;

  arp_cache_responder dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void learn_peer(input logic [31:0] ip, input logic [47:0] mac);
    int slot;
    int i;
    slot = -1;
    for (i = 0; i < SLOTS; i++)
      if (slot < 0 && cache_ip[i] == ip) slot = i;
    for (i = 0; i < SLOTS; i++)
      if (slot < 0 && (cache_ip[i] == '0 || cache_deadline[i] <= clock_ms)) slot = i;
    if (slot < 0) slot = 0;
    cache_ip[slot] = ip;
    cache_mac[slot] = mac;
    cache_deadline[slot] = clock_ms + 64'(lifetime_ms);
  endfunction

  function automatic result_t arp_answer(input item_t w);
    result_t r;
    bit well;
    bit hit;
    int i;
    r = '0;
    hit = 1'b0;
    case (w.func)
      FUNC_PACKET: begin
        well = w.packet_len >= MIN_PKT_LEN && w.hw_type == HTYPE_ETH &&
               w.proto_type == PTYPE_IPV4 && w.hw_len == HW_ADDR_LEN &&
               w.proto_len == PROTO_ADDR_LEN && w.dest_ip == own_ip;
        if (well && w.opcode == ARP_OP_REPLY) begin
          learn_peer(w.sender_ip, w.sender_mac);
          r.status = ST_LEARNED;
        end else if (well && w.opcode == ARP_OP_REQUEST) begin
          learn_peer(w.sender_ip, w.sender_mac);
          r.status = ST_REPLIED;
          r.send_frame = 1'b1;
          r.out_opcode = OUT_OP_REPLY;
          r.peer_mac = w.sender_mac;
          r.peer_ip = w.sender_ip;
        end else begin
          r.status = ST_DROPPED;
        end
      end
      FUNC_LOOKUP: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!hit && cache_ip[i] == w.query_ip && cache_deadline[i] > clock_ms) begin
            hit = 1'b1;
            r.found_mac = cache_mac[i];
          end
        end
        if (hit) begin
          r.status = ST_HIT;
        end else begin
          r.status = ST_MISS;
          r.send_frame = 1'b1;
          r.out_opcode = OUT_OP_REQUEST;
          r.peer_mac = BCAST_MAC;
          r.peer_ip = w.query_ip;
        end
      end
      FUNC_TICK: begin
        clock_ms = clock_ms + 64'd1;
        r.status = ST_TICK;
      end
      default: r.status = ST_DROPPED;
    endcase
    return r;
  endfunction

  function automatic result_t outcome(input logic [2:0] st, input logic send,
                                      input logic [1:0] op, input logic [47:0] pmac,
                                      input logic [31:0] pip, input logic [47:0] fmac);
    result_t r;
    r.status = st;
    r.send_frame = send;
    r.out_opcode = op;
    r.peer_mac = pmac;
    r.peer_ip = pip;
    r.found_mac = fmac;
    return r;
  endfunction

  function automatic item_t arp_pkt(input logic [15:0] op, input logic [47:0] smac,
                                    input logic [31:0] sip, input logic [31:0] tip);
    item_t w;
    w = '0;
    w.func = FUNC_PACKET;
    w.packet_len = MIN_PKT_LEN;
    w.hw_type = HTYPE_ETH;
    w.proto_type = PTYPE_IPV4;
    w.hw_len = HW_ADDR_LEN;
    w.proto_len = PROTO_ADDR_LEN;
    w.opcode = op;
    w.sender_mac = smac;
    w.sender_ip = sip;
    w.dest_ip = tip;
    return w;
  endfunction

  function automatic item_t lookup_word(input logic [31:0] q);
    item_t w;
    w = '0;
    w.func = FUNC_LOOKUP;
    w.query_ip = q;
    return w;
  endfunction

  function automatic item_t tick_word();
    item_t w;
    w = '0;
    w.func = FUNC_TICK;
    return w;
  endfunction

  function automatic void add_row(input item_t w, input bit typed, input result_t want);
    row_t r;
    r.w = w;
    r.typed = typed;
    r.want = want;
    plan.push_back(r);
  endfunction

  function automatic item_t noise_word();
    logic [255:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t random_word();
    item_t w;
    int pick;
    w = noise_word();
    pick = $urandom_range(99);
    if (pick < 20) begin
      w.func = FUNC_TICK;
    end else if (pick < 55) begin
      w.func = FUNC_LOOKUP;
      if ($urandom_range(4) != 0) w.query_ip = peer_pool[$urandom_range(POOL - 1)];
    end else if (pick < 95) begin
      w.func = FUNC_PACKET;
      w.packet_len = 11'($urandom_range(2047, 28));
      w.hw_type = HTYPE_ETH;
      w.proto_type = PTYPE_IPV4;
      w.hw_len = HW_ADDR_LEN;
      w.proto_len = PROTO_ADDR_LEN;
      w.opcode = $urandom_range(1) ? ARP_OP_REQUEST : ARP_OP_REPLY;
      w.sender_ip = peer_pool[$urandom_range(POOL - 1)];
      w.dest_ip = own_ip;
      if (pick >= 85) begin
        case ($urandom_range(6))
          0: w.packet_len = 11'($urandom_range(27));
          1: w.hw_type = 16'($urandom);
          2: w.proto_type = 16'($urandom);
          3: w.hw_len = 8'($urandom);
          4: w.proto_len = 8'($urandom);
          5: w.opcode = 16'($urandom);
          default: w.dest_ip = $urandom;
        endcase
      end
    end else begin
      w.func = FUNC_SPARE;
    end
    return w;
  endfunction

  task automatic push_word(input item_t w, input bit typed, input result_t want);
    result_t r;
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = arp_answer(w);
    answers_due.push_back(typed ? want : r);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < 36) begin
      start <= 1'b0;
      item <= noise_word();
      @(posedge clk);
    end
  endtask

  task automatic drain_answers();
    start <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LOCAL_IP: own_ip = val[31:0];
      REG_LOCAL_MAC: own_mac = val;
      REG_LIFETIME: lifetime_ms = val[31:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        note_mismatch("result word with nothing pending");
      end else begin
        want = answers_due.pop_front();
        if (result.status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
        if (result.send_frame !== want.send_frame)
          note_mismatch($sformatf("send_frame %0b, want %0b", result.send_frame,
                                  want.send_frame));
        if (result.out_opcode !== want.out_opcode)
          note_mismatch($sformatf("out_opcode %0d, want %0d", result.out_opcode,
                                  want.out_opcode));
        if (result.peer_mac !== want.peer_mac)
          note_mismatch($sformatf("peer_mac %h, want %h", result.peer_mac, want.peer_mac));
        if (result.peer_ip !== want.peer_ip)
          note_mismatch($sformatf("peer_ip %h, want %h", result.peer_ip, want.peer_ip));
        if (result.found_mac !== want.found_mac)
          note_mismatch($sformatf("found_mac %h, want %h", result.found_mac,
                                  want.found_mac));
      end
    end
  end

  initial begin
    logic [31:0] here;
    logic [31:0] life;
    logic [31:0] ip;
    logic [47:0] mac;
    item_t w;
    result_t dropped;
    int n;
    int phase;
    bit quiet;

    own_ip = '0;
    own_mac = '0;
    lifetime_ms = LIFETIME_RESET;
    clock_ms = '0;
    for (n = 0; n < SLOTS; n++) begin
      cache_ip[n] = '0;
      cache_mac[n] = '0;
      cache_deadline[n] = '0;
    end
    dropped = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    here = 32'hC0A8_0A01;
    write_reg(REG_LOCAL_IP, {16'hA5A5, here});
    write_reg(REG_LOCAL_MAC, 48'h0200_5E10_2030);
    write_reg(REG_LIFETIME, 48'd3);
    write_reg(REG_SPARE, 48'hFFFF_FFFF_FFFF);

    add_row(lookup_word('0), 1'b1,
            outcome(ST_MISS, 1'b1, OUT_OP_REQUEST, BCAST_MAC, '0, '0));
    add_row(lookup_word('1), 1'b1,
            outcome(ST_MISS, 1'b1, OUT_OP_REQUEST, BCAST_MAC, '1, '0));
    w = noise_word();
    w.func = FUNC_SPARE;
    add_row(w, 1'b1, dropped);
    add_row(tick_word(), 1'b1, outcome(ST_TICK, 1'b0, OUT_OP_NONE, '0, '0, '0));
    w = arp_pkt(ARP_OP_REQUEST, 48'h1, 32'h0A00_0009, here);
    w.packet_len = 11'd27;
    add_row(w, 1'b1, dropped);
    w = arp_pkt(ARP_OP_REQUEST, 48'h1, 32'h0A00_0009, here);
    w.hw_type = 16'h0000;
    add_row(w, 1'b1, dropped);
    w = arp_pkt(ARP_OP_REQUEST, 48'h1, 32'h0A00_0009, here);
    w.proto_type = 16'h0806;
    add_row(w, 1'b1, dropped);
    w = arp_pkt(ARP_OP_REQUEST, 48'h1, 32'h0A00_0009, here);
    w.hw_len = 8'd5;
    add_row(w, 1'b1, dropped);
    w = arp_pkt(ARP_OP_REQUEST, 48'h1, 32'h0A00_0009, here);
    w.proto_len = 8'hFF;
    add_row(w, 1'b1, dropped);
    add_row(arp_pkt(16'h0000, 48'h1, 32'h0A00_0009, here), 1'b1, dropped);
    add_row(arp_pkt(16'hFFFF, 48'h1, 32'h0A00_0009, here), 1'b1, dropped);
    add_row(arp_pkt(ARP_OP_REQUEST, 48'h1, 32'h0A00_0009, here ^ 32'h1), 1'b1, dropped);
    w = arp_pkt(ARP_OP_REQUEST, '1, '1, here);
    w.packet_len = 11'h7FF;
    add_row(w, 1'b1, outcome(ST_REPLIED, 1'b1, OUT_OP_REPLY, '1, '1, '0));
    add_row(arp_pkt(ARP_OP_REPLY, 48'h0000_0000_0001, 32'h0A00_0001, here), 1'b1,
            outcome(ST_LEARNED, 1'b0, OUT_OP_NONE, '0, '0, '0));
    add_row(lookup_word(32'h0A00_0001), 1'b0, dropped);
    add_row(lookup_word('1), 1'b0, dropped);
    add_row(arp_pkt(ARP_OP_REQUEST, 48'h1122_3344_5566, '0, here), 1'b1,
            outcome(ST_REPLIED, 1'b1, OUT_OP_REPLY, 48'h1122_3344_5566, '0, '0));
    add_row(lookup_word('0), 1'b0, dropped);
    add_row(arp_pkt(ARP_OP_REPLY, 48'h8000_0000_0000, 32'h0A00_0001, here), 1'b1,
            outcome(ST_LEARNED, 1'b0, OUT_OP_NONE, '0, '0, '0));
    repeat (3) add_row(tick_word(), 1'b1, outcome(ST_TICK, 1'b0, OUT_OP_NONE, '0, '0, '0));
    add_row(lookup_word(32'h0A00_0001), 1'b0, dropped);
    add_row(lookup_word('0), 1'b0, dropped);
    add_row(arp_pkt(ARP_OP_REQUEST, '0, 32'h0A00_0002, here), 1'b1,
            outcome(ST_REPLIED, 1'b1, OUT_OP_REPLY, '0, 32'h0A00_0002, '0));

    foreach (plan[i]) begin
      idle_gap();
      push_word(plan[i].w, plan[i].typed, plan[i].want);
    end

    for (phase = 0; phase < PHASES; phase++) begin
      drain_answers();
      ip = $urandom;
      mac = {16'($urandom), 32'($urandom)};
      case (phase)
        0: life = LIFETIME_RESET;
        1: begin
          life = 32'd1;
          mac = '1;
        end
        2: begin
          life = 32'd0;
          mac = '0;
        end
        3: begin
          life = '1;
          ip = '0;
        end
        4: begin
          life = $urandom_range(20, 2);
          ip = '1;
        end
        5: life = $urandom_range(200, 20);
        default: life = $urandom;
      endcase
      write_reg(REG_LOCAL_IP, {16'($urandom), ip});
      write_reg(REG_LOCAL_MAC, mac);
      write_reg(REG_LIFETIME, {16'($urandom), life});
      write_reg(REG_SPARE, {16'($urandom), 32'($urandom)});
      for (n = 0; n < POOL; n++)
        peer_pool[n] = (n == 0 && phase % 2 == 0) ? '0 : $urandom;
      quiet = (phase == 3);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if (!quiet) idle_gap();
        if ($urandom_range(149) == 0) drain_answers();
        push_word(random_word(), 1'b0, dropped);
      end
    end

    drain_answers();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
